@@ hw/rtl/easps_pkg.sv @@
// easps_pkg: shared constants, types and helpers for the expansion audio synth core
// no dependencies; imported by the core and its port checker
`timescale 1ns / 1ps

package easps_pkg;

   // transaction kinds carried on req_tuser
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // bus address decode
   localparam logic [15:0] ADDR_MASK    = 16'hF003;
   localparam logic [15:0] ADDR_CONTROL = 16'h9003;
   localparam logic [3:0]  BANK_PULSE_ONE = 4'h9;
   localparam logic [3:0]  BANK_PULSE_TWO = 4'hA;
   localparam logic [3:0]  BANK_SAW       = 4'hB;

   // register offsets inside a bank
   localparam logic [1:0] REG_CONTROL = 2'd0;
   localparam logic [1:0] REG_PERIOD_LO = 2'd1;
   localparam logic [1:0] REG_PERIOD_HI = 2'd2;

   // frequency shift codes
   localparam logic [1:0] SHIFT_NONE = 2'd0;
   localparam logic [1:0] SHIFT_FOUR = 2'd1;
   localparam logic [1:0] SHIFT_EIGHT = 2'd2;

   // saw step wraps after this many steps
   localparam logic [3:0] SAW_STEPS = 4'd14;

   // stream payload widths
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   typedef logic [12:0] divider_type;
   typedef logic [11:0] period_type;

   // divider reload: shifted period plus one
   function automatic divider_type reload_value(input period_type period,
                                                input logic [1:0] shift);
      period_type shifted;
      case (shift)
         SHIFT_FOUR:  shifted = period >> 4;
         SHIFT_EIGHT: shifted = period >> 8;
         default:     shifted = period;
      endcase
      return {1'b0, shifted} + 13'd1;
   endfunction

endpackage

@@ hw/rtl/expansion_audio_pulse_saw_synth_core.sv @@
// expansion_audio_pulse_saw_synth_core: two pulse voices and one sawtooth voice
// behind bus registers; depends on easps_pkg
`timescale 1ns / 1ps

// Each request transaction is either a register write (req_tuser = 0) or one
// clock tick (req_tuser = 1). A write updates the voice registers decoded from
// address & 0xF003 and gives no response; a tick advances the enabled voices,
// unless halted, and returns one response with the three raw levels and their
// sum. The block takes one transaction per cycle while no tick is stalled: it
// lands in an input register and is processed by the single-pass update logic,
// which loads a tick's response into the response register. A tick stalls in
// the input register only while the response register is full and not being
// taken; writes never wait for the response side.
module expansion_audio_pulse_saw_synth_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // address [15:0], data [23:16]
   input  logic [easps_pkg::REQ_DATA_W-1:0]    req_tdata,
   // operation [0]
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // pulse_one_level [3:0], pulse_two_level [7:4], saw_level [12:8],
   // mixed_level [18:13], zero [23:19]
   output logic [easps_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import easps_pkg::*;

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic                  in_op_ff;
   logic [15:0]           in_addr_ff;
   logic [7:0]            in_data_ff;
   logic                  in_fire;

   // response register
   logic                  out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;

   // voice state
   logic [3:0]  pulse_volume_ff [2], pulse_volume_in [2];
   logic [2:0]  pulse_duty_ff   [2], pulse_duty_in   [2];
   logic        pulse_const_ff  [2], pulse_const_in  [2];
   logic        pulse_enable_ff [2], pulse_enable_in [2];
   period_type  pulse_period_ff [2], pulse_period_in [2];
   logic [3:0]  pulse_step_ff   [2], pulse_step_in   [2];
   divider_type pulse_div_ff    [2], pulse_div_in    [2];
   logic [5:0]  saw_rate_ff,   saw_rate_in;
   logic        saw_enable_ff, saw_enable_in;
   period_type  saw_period_ff, saw_period_in;
   logic [3:0]  saw_step_ff,   saw_step_in;
   logic [7:0]  saw_acc_ff,    saw_acc_in;
   divider_type saw_div_ff,    saw_div_in;
   logic        halt_ff,       halt_in;
   logic [1:0]  shift_ff,      shift_in;

   // handshake: a tick needs room in the response register
   assign in_fire    = in_valid_ff &&
                       (in_op_ff == OP_WRITE || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || in_fire;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !in_fire);

   // single-pass update of voice state and response
   always_comb begin
      logic [15:0] masked;
      logic [3:0]  bank;
      logic [1:0]  offset;
      logic [3:0]  pulse_level [2];
      logic [4:0]  saw_level;
      logic [3:0]  saw_next;
      logic [5:0]  mixed;
      logic        sel;

      pulse_volume_in = pulse_volume_ff;
      pulse_duty_in   = pulse_duty_ff;
      pulse_const_in  = pulse_const_ff;
      pulse_enable_in = pulse_enable_ff;
      pulse_period_in = pulse_period_ff;
      pulse_step_in   = pulse_step_ff;
      pulse_div_in    = pulse_div_ff;
      saw_rate_in     = saw_rate_ff;
      saw_enable_in   = saw_enable_ff;
      saw_period_in   = saw_period_ff;
      saw_step_in     = saw_step_ff;
      saw_acc_in      = saw_acc_ff;
      saw_div_in      = saw_div_ff;
      halt_in         = halt_ff;
      shift_in        = shift_ff;
      out_data_in     = out_data_ff;

      masked = in_addr_ff & ADDR_MASK;
      bank   = masked[15:12];
      offset = masked[1:0];
      sel    = (bank == BANK_PULSE_TWO);
      pulse_level[0] = 4'd0;
      pulse_level[1] = 4'd0;
      saw_level = 5'd0;
      saw_next  = 4'd0;
      mixed     = 6'd0;

      if (in_fire && in_op_ff == OP_WRITE) begin
         // register write
         if (masked == ADDR_CONTROL) begin
            halt_in = in_data_ff[0];
            if (in_data_ff[2]) begin
               shift_in = SHIFT_EIGHT;
            end else if (in_data_ff[1]) begin
               shift_in = SHIFT_FOUR;
            end else begin
               shift_in = SHIFT_NONE;
            end
         end else if (bank == BANK_PULSE_ONE || bank == BANK_PULSE_TWO) begin
            case (offset)
               REG_CONTROL: begin
                  pulse_volume_in[sel] = in_data_ff[3:0];
                  pulse_duty_in[sel]   = in_data_ff[6:4];
                  pulse_const_in[sel]  = in_data_ff[7];
               end
               REG_PERIOD_LO: begin
                  pulse_period_in[sel] = {pulse_period_ff[sel][11:8], in_data_ff};
               end
               REG_PERIOD_HI: begin
                  pulse_period_in[sel] = {in_data_ff[3:0], pulse_period_ff[sel][7:0]};
                  pulse_enable_in[sel] = in_data_ff[7];
                  if (!in_data_ff[7]) begin
                     pulse_step_in[sel] = 4'd0;
                  end
               end
               default: begin
               end
            endcase
         end else if (bank == BANK_SAW) begin
            case (offset)
               REG_CONTROL: begin
                  saw_rate_in = in_data_ff[5:0];
               end
               REG_PERIOD_LO: begin
                  saw_period_in = {saw_period_ff[11:8], in_data_ff};
               end
               REG_PERIOD_HI: begin
                  saw_period_in = {in_data_ff[3:0], saw_period_ff[7:0]};
                  saw_enable_in = in_data_ff[7];
                  if (!in_data_ff[7]) begin
                     saw_step_in = 4'd0;
                  end
               end
               default: begin
               end
            endcase
         end
      end else if (in_fire) begin
         // pulse voices: count down, advance step, pick level
         for (int v = 0; v < 2; v++) begin
            if (pulse_enable_ff[v]) begin
               if (!halt_ff) begin
                  if (pulse_div_ff[v] <= 13'd1) begin
                     pulse_div_in[v]  = reload_value(pulse_period_ff[v], shift_ff);
                     pulse_step_in[v] = pulse_step_ff[v] + 4'd1;
                  end else begin
                     pulse_div_in[v] = pulse_div_ff[v] - 13'd1;
                  end
               end
               if (pulse_const_ff[v] || pulse_step_in[v] <= {1'b0, pulse_duty_ff[v]}) begin
                  pulse_level[v] = pulse_volume_ff[v];
               end
            end
         end

         // saw voice: step modulo fourteen, accumulate on even nonzero steps, clear on wrap
         if (saw_enable_ff) begin
            if (!halt_ff) begin
               if (saw_div_ff <= 13'd1) begin
                  saw_div_in = reload_value(saw_period_ff, shift_ff);
                  saw_next   = (saw_step_ff == SAW_STEPS - 4'd1) ? 4'd0
                                                                 : saw_step_ff + 4'd1;
                  saw_step_in = saw_next;
                  if (saw_next == 4'd0) begin
                     saw_acc_in = 8'd0;
                  end else if (!saw_next[0]) begin
                     saw_acc_in = saw_acc_ff + {2'b00, saw_rate_ff};
                  end
               end else begin
                  saw_div_in = saw_div_ff - 13'd1;
               end
            end
            saw_level = saw_acc_in[7:3];
         end

         // response payload
         mixed = {2'b00, pulse_level[0]} + {2'b00, pulse_level[1]} + {1'b0, saw_level};
         out_data_in = {5'd0, mixed, saw_level, pulse_level[1], pulse_level[0]};
      end
   end

   // response valid: hold until taken, load on each tick
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      if (in_fire && in_op_ff == OP_TICK) begin
         out_valid_in = 1'b1;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // control and voice state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 2; i++) begin
            pulse_volume_ff[i] <= 4'd0;
            pulse_duty_ff[i]   <= 3'd0;
            pulse_const_ff[i]  <= 1'b0;
            pulse_enable_ff[i] <= 1'b0;
            pulse_period_ff[i] <= 12'd0;
            pulse_step_ff[i]   <= 4'd0;
            pulse_div_ff[i]    <= 13'd1;
         end
         saw_rate_ff   <= 6'd0;
         saw_enable_ff <= 1'b0;
         saw_period_ff <= 12'd0;
         saw_step_ff   <= 4'd0;
         saw_acc_ff    <= 8'd0;
         saw_div_ff    <= 13'd1;
         halt_ff       <= 1'b0;
         shift_ff      <= SHIFT_NONE;
      end else begin
         in_valid_ff     <= in_valid_in;
         out_valid_ff    <= out_valid_in;
         pulse_volume_ff <= pulse_volume_in;
         pulse_duty_ff   <= pulse_duty_in;
         pulse_const_ff  <= pulse_const_in;
         pulse_enable_ff <= pulse_enable_in;
         pulse_period_ff <= pulse_period_in;
         pulse_step_ff   <= pulse_step_in;
         pulse_div_ff    <= pulse_div_in;
         saw_rate_ff     <= saw_rate_in;
         saw_enable_ff   <= saw_enable_in;
         saw_period_ff   <= saw_period_in;
         saw_step_ff     <= saw_step_in;
         saw_acc_ff      <= saw_acc_in;
         saw_div_ff      <= saw_div_in;
         halt_ff         <= halt_in;
         shift_ff        <= shift_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff   <= req_tuser;
         in_addr_ff <= req_tdata[15:0];
         in_data_ff <= req_tdata[23:16];
      end
      out_data_ff <= out_data_in;
   end

endmodule

@@ hw/rtl/easps_port_checker.sv @@
// easps_port_checker: port-level checks on the expansion audio synth core
// depends on easps_pkg; bound to expansion_audio_pulse_saw_synth_core below
`timescale 1ns / 1ps

module easps_port_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [easps_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import easps_pkg::*;

   // no response right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // stalled response transaction holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // mixed level is the sum of the three voice levels
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[18:13] ==
         ({2'b00, rsp_tdata[3:0]} + {2'b00, rsp_tdata[7:4]} + {1'b0, rsp_tdata[12:8]}))
      else $error("mixed level mismatch");

   // padding bits of the response stay zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:19] == 5'd0)
      else $error("response padding not zero");

   // an idle pipeline never refuses a request
   assert property (@(posedge clock) disable iff (reset)
      !$past(req_tvalid) && !rsp_tvalid |-> req_tready)
      else $error("request refused while idle");

endmodule

bind expansion_audio_pulse_saw_synth_core easps_port_checker u_easps_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
